// ===== rtl/core/stq_pkg.sv =====
// Shared constants, types and helpers for the sorted timer queue.
package stq_pkg;

  localparam int TIMERS = 32;
  localparam int CLOCKS = 3;
  localparam int ID_W   = $clog2(TIMERS);
  localparam int CLK_W  = 2;
  localparam int KIND_W = 3;
  localparam int MASK_W = 3;

  localparam logic [KIND_W-1:0] KIND_ARM      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RUN      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEADLINE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY    = 3'd4;

  localparam logic [MASK_W-1:0] MASK_RESET = 3'd7;

  localparam logic signed [63:0] INT32_MAX_V = 64'sd2147483647;
  localparam logic signed [63:0] INT64_MAX_V = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] INT64_MIN_V = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] MINUS_ONE   = -64'sd1;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;

  typedef struct packed {
    logic                    valid;
    logic [ID_W-1:0]         id;
    logic [CLK_W-1:0]        clk_sel;
    logic signed [63:0]      exp;
  } cell_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [ID_W-1:0]  rm_id;
    logic [CLK_W-1:0] sel_clk;
    cell_t            ins;
  } cell_ctrl_t;

  typedef struct packed {
    logic le;
    logic same_le;
    logic head;
  } cell_flag_t;

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] r;
    r = a - b;
    if ((a[63] ^ b[63]) & (a[63] ^ r[63]))
      sat_sub = a[63] ? INT64_MIN_V : INT64_MAX_V;
    else
      sat_sub = r;
  endfunction

endpackage

// ===== rtl/core/stq_ifs.sv =====
// Request and result channel interfaces of the sorted timer queue.
interface stq_in_if;
  import stq_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [ID_W-1:0]    timer_id;
  logic [CLK_W-1:0]   clock_id;
  logic signed [63:0] time_value;
  modport source (output valid, kind, timer_id, clock_id, time_value, input ready);
  modport sink   (input valid, kind, timer_id, clock_id, time_value, output ready);
endinterface

interface stq_out_if;
  import stq_pkg::*;
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    out_timer;
  logic               fired;
  logic signed [63:0] out_value;
  logic               new_head;
  logic               last;
  modport source (output valid, out_timer, fired, out_value, new_head, last, input ready);
  modport sink   (input valid, out_timer, fired, out_value, new_head, last, output ready);
endinterface

// ===== rtl/core/sorted_timer_queue_unit.sv =====
// Top level: per-clock sorted timer lists held in a shifting row of cells.
// All timers of all clocks sit in one row of TIMERS cells, ordered by clock and then
// by expiry, so each clock's list is a contiguous run whose first cell is its head.
// The row moves by one insert or one removal per cycle unless the output holds it, and
// the expiry store is a memory with a registered read. An arm unlinks the timer, reads
// its old expiry from memory and then inserts it; an expiry query reads the memory
// before its result; a run removes and reports fired timers one by one. One request is
// in work at a time; the result register lets the next request in while a result waits.
module sorted_timer_queue_unit
  import stq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [MASK_W-1:0] cfg_wdata,
  stq_in_if.sink            in_req,
  stq_out_if.source         out_rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ARM  = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_DEL  = 3'd3;
  localparam logic [2:0] S_RUN  = 3'd4;
  localparam logic [2:0] S_DL   = 3'd5;
  localparam logic [2:0] S_QRD  = 3'd6;
  localparam logic [2:0] S_ONE  = 3'd7;

  logic [2:0]         state, state_next;
  logic [MASK_W-1:0]  enable_mask;
  logic [KIND_W-1:0]  kind_q;
  logic [ID_W-1:0]    tid_q;
  logic [CLK_W-1:0]   clk_q;
  logic signed [63:0] t_q;

  logic signed [63:0] exp_mem [TIMERS];
  logic signed [63:0] rd_data;
  logic [TIMERS-1:0]  exp_written;
  logic [TIMERS-1:0]  linked;

  cell_ctrl_t         ctrl;
  cell_t              cells [TIMERS];
  cell_flag_t         flags [TIMERS];
  logic [TIMERS:0]    rm_seen;
  logic [TIMERS:0]    head_seen;
  logic [TIMERS:0]    le_chain;
  logic [TIMERS-1:0]  head_vec;
  cell_t              empty_cell;

  logic               head_hit;
  logic [ID_W-1:0]    head_id;
  logic signed [63:0] head_exp;
  logic               any_same_le;

  logic               pend_valid;
  logic [ID_W-1:0]    pend_id;
  logic signed [63:0] pend_exp;

  logic               clk_ok;
  logic               run_en;
  logic               run_fire;
  logic               out_free;
  logic               accept;
  logic signed [63:0] old_exp;
  logic signed [63:0] interval;
  logic signed [63:0] dl_delta;

  logic               emit;
  logic [ID_W-1:0]    e_timer;
  logic               e_fired;
  logic signed [63:0] e_value;
  logic               e_head;
  logic               e_last;

  assign clk_ok   = ({1'b0, clk_q} < (CLK_W+1)'(CLOCKS));
  assign run_en   = clk_ok && enable_mask[clk_q];
  assign out_free = !out_rsp.valid || out_rsp.ready;
  assign in_req.ready = (state == S_IDLE);
  assign accept   = in_req.valid && in_req.ready;

  // Cell row
  assign empty_cell = '0;
  assign rm_seen[0]   = 1'b0;
  assign head_seen[0] = 1'b0;
  assign le_chain[0]  = 1'b1;

  genvar gi;
  generate
    for (gi = 0; gi < TIMERS; gi++) begin : g_cell
      stq_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .ctrl         (ctrl),
        .left         ((gi == 0) ? empty_cell : cells[(gi == 0) ? 0 : gi-1]),
        .right        ((gi == TIMERS-1) ? empty_cell : cells[(gi == TIMERS-1) ? gi : gi+1]),
        .left_le      (le_chain[gi]),
        .rm_seen_in   (rm_seen[gi]),
        .head_seen_in (head_seen[gi]),
        .cur          (cells[gi]),
        .rm_seen_out  (rm_seen[gi+1]),
        .head_seen_out(head_seen[gi+1]),
        .flag         (flags[gi])
      );
      assign le_chain[gi+1] = flags[gi].le;
      assign head_vec[gi]   = flags[gi].head;
    end
  endgenerate

  always_comb begin
    head_id     = '0;
    head_exp    = '0;
    any_same_le = 1'b0;
    for (int i = 0; i < TIMERS; i++) begin
      if (head_vec[i]) begin
        head_id  = head_id | cells[i].id;
        head_exp = head_exp | cells[i].exp;
      end
      any_same_le = any_same_le | flags[i].same_le;
    end
    head_hit = clk_ok && (|head_vec);
  end

  assign run_fire = run_en && head_hit && (head_exp <= t_q);
  assign old_exp  = exp_written[tid_q] ? rd_data : '0;
  assign interval = ((old_exp != 0) && (t_q > old_exp)) ? sat_sub(t_q, old_exp) : '0;

  always_comb begin
    logic signed [63:0] d;
    d = sat_sub(head_exp, t_q);
    if (!head_hit) dl_delta = INT32_MAX_V;
    else if (d < 0) dl_delta = '0;
    else dl_delta = d;
  end

  // Row control
  always_comb begin
    ctrl.op          = OP_HOLD;
    ctrl.rm_id       = tid_q;
    ctrl.sel_clk     = clk_q;
    ctrl.ins.valid   = 1'b1;
    ctrl.ins.id      = tid_q;
    ctrl.ins.clk_sel = clk_q;
    ctrl.ins.exp     = t_q;
    case (state)
      S_ARM: ctrl.op = OP_REMOVE;
      S_DEL: begin
        // an arm on a clock with no list lands here and must leave the timer alone
        if (kind_q == KIND_DELETE) ctrl.op = OP_REMOVE;
      end
      S_INS: begin
        if (out_free) ctrl.op = OP_INSERT;
      end
      S_RUN: begin
        ctrl.rm_id = head_id;
        if (out_free && run_fire) ctrl.op = OP_REMOVE;
      end
      default: ;
    endcase
  end

  // Result selection and sequencing
  always_comb begin
    state_next = state;
    emit    = 1'b0;
    e_timer = tid_q;
    e_fired = 1'b0;
    e_value = '0;
    e_head  = 1'b0;
    e_last  = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_req.kind)
            KIND_ARM: begin
              if ({1'b0, in_req.clock_id} < (CLK_W+1)'(CLOCKS)) state_next = S_ARM;
              else state_next = S_DEL;
            end
            KIND_DELETE:   state_next = S_DEL;
            KIND_RUN:      state_next = S_RUN;
            KIND_DEADLINE: state_next = S_DL;
            KIND_QUERY:    state_next = S_QRD;
            default:       state_next = S_ONE;
          endcase
        end
      end
      S_ARM: state_next = S_INS;
      S_INS: begin
        emit    = 1'b1;
        e_value = interval;
        e_head  = !any_same_le;
        if (out_free) state_next = S_IDLE;
      end
      S_DEL: begin
        emit = 1'b1;
        if (out_free) state_next = S_IDLE;
      end
      S_RUN: begin
        if (run_fire) begin
          emit    = pend_valid;
          e_timer = pend_id;
          e_fired = 1'b1;
          e_value = pend_exp;
          e_last  = 1'b0;
        end else begin
          emit    = 1'b1;
          e_timer = pend_valid ? pend_id : '0;
          e_fired = pend_valid;
          e_value = pend_valid ? pend_exp : '0;
          if (out_free) state_next = S_IDLE;
        end
      end
      S_DL: begin
        emit    = 1'b1;
        e_timer = head_hit ? head_id : '0;
        e_value = dl_delta;
        if (out_free) state_next = S_IDLE;
      end
      S_QRD: state_next = S_ONE;
      S_ONE: begin
        emit = 1'b1;
        if (kind_q == KIND_QUERY) begin
          e_value = linked[tid_q] ? rd_data : MINUS_ONE;
        end else begin
          e_timer = '0;
        end
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      enable_mask <= MASK_RESET;
      exp_written <= '0;
      linked      <= '0;
      pend_valid  <= 1'b0;
      out_rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) enable_mask <= cfg_wdata;
      if (accept) pend_valid <= 1'b0;
      if (out_free) out_rsp.valid <= emit;
      case (state)
        S_DEL: begin
          if (kind_q == KIND_DELETE) linked[tid_q] <= 1'b0;
        end
        S_INS: begin
          if (out_free) begin
            linked[tid_q]      <= 1'b1;
            exp_written[tid_q] <= 1'b1;
          end
        end
        S_RUN: begin
          if (out_free && run_fire) begin
            pend_valid      <= 1'b1;
            linked[head_id] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= in_req.kind;
      tid_q  <= in_req.timer_id;
      clk_q  <= in_req.clock_id;
      t_q    <= in_req.time_value;
    end
    if (state == S_RUN && out_free && run_fire) begin
      pend_id  <= head_id;
      pend_exp <= head_exp;
    end
    if (out_free && emit) begin
      out_rsp.out_timer <= e_timer;
      out_rsp.fired     <= e_fired;
      out_rsp.out_value <= e_value;
      out_rsp.new_head  <= e_head;
      out_rsp.last      <= e_last;
    end
  end

  // Expiry store
  always_ff @(posedge clk) begin
    rd_data <= exp_mem[tid_q];
    if (state == S_INS && out_free) exp_mem[tid_q] <= t_q;
  end

`ifndef SYNTHESIS
  logic [TIMERS-1:0] cell_valid;
  always_comb begin
    for (int i = 0; i < TIMERS; i++) cell_valid[i] = cells[i].valid;
  end

  a_one_head: assert property (@(posedge clk) disable iff (rst) $onehot0(head_vec))
    else $error("more than one head cell for a clock");
  a_row_matches_linked: assert property (@(posedge clk) disable iff (rst)
      (state == S_IDLE) |-> ($countones(cell_valid) == $countones(linked)))
    else $error("cell row occupancy differs from pending timer count");
  a_row_compact: assert property (@(posedge clk) disable iff (rst)
      !cell_valid[0] |-> (cell_valid == '0))
    else $error("cell row has a gap at the front");
`endif

endmodule

// ===== rtl/core/stq_cell.sv =====
// One slot of the sorted timer row; shifts toward either neighbor.
module stq_cell
  import stq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  cell_t      left,
  input  cell_t      right,
  input  logic       left_le,
  input  logic       rm_seen_in,
  input  logic       head_seen_in,
  output cell_t      cur,
  output logic       rm_seen_out,
  output logic       head_seen_out,
  output cell_flag_t flag
);

  logic same_clk;

  assign same_clk = cur.valid && (cur.clk_sel == ctrl.sel_clk);

  // Entries are kept ordered by clock, then expiry, oldest first on ties.
  assign flag.le = cur.valid && ((cur.clk_sel < ctrl.ins.clk_sel) ||
                   ((cur.clk_sel == ctrl.ins.clk_sel) && (cur.exp <= ctrl.ins.exp)));
  assign flag.same_le = flag.le && (cur.clk_sel == ctrl.ins.clk_sel);
  assign flag.head = same_clk && !head_seen_in;
  assign head_seen_out = head_seen_in | same_clk;
  assign rm_seen_out = rm_seen_in | (cur.valid && (cur.id == ctrl.rm_id));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      case (ctrl.op)
        OP_REMOVE: begin
          if (rm_seen_out) cur <= right;
        end
        OP_INSERT: begin
          if (!flag.le) begin
            if (left_le) cur <= ctrl.ins;
            else cur <= left;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
